// ===== hw/rtl/itic_pkg.sv =====
// Shared types, register addresses and timer lookup functions of the I/O timer block.
package itic_pkg;

	typedef enum logic [2:0] {
		OP_READ  = 3'd0,
		OP_WRITE = 3'd1,
		OP_TICK  = 3'd2,
		OP_KEY   = 3'd3,
		OP_PEEK  = 3'd4
	} op_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_EXEC = 7'b0000010,
		ST_TRD  = 7'b0000100,
		ST_TCHK = 7'b0001000,
		ST_TDIV = 7'b0010000,
		ST_TWB  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	typedef logic [4:0] raddr_t;

	localparam raddr_t RA_DIR_A     = 5'h00;
	localparam raddr_t RA_PORT_A    = 5'h01;
	localparam raddr_t RA_DIR_B     = 5'h02;
	localparam raddr_t RA_PORT_B    = 5'h03;
	localparam raddr_t RA_DIR_C     = 5'h04;
	localparam raddr_t RA_PORT_C    = 5'h05;
	localparam raddr_t RA_DIR_D     = 5'h06;
	localparam raddr_t RA_PORT_D    = 5'h07;
	localparam raddr_t RA_SER_MODE  = 5'h08;
	localparam raddr_t RA_SER_CTL   = 5'h09;
	localparam raddr_t RA_SER_STAT  = 5'h0a;
	localparam raddr_t RA_SER_AUX   = 5'h0b;
	localparam raddr_t RA_TAPE_STAT = 5'h0c;
	localparam raddr_t RA_TAPE_DATA = 5'h0d;
	localparam raddr_t RA_T0_CTL    = 5'h0e;
	localparam raddr_t RA_T0_VAL    = 5'h0f;
	localparam raddr_t RA_T1_CTL    = 5'h10;
	localparam raddr_t RA_T1_VAL    = 5'h11;
	localparam raddr_t RA_T2_CTL    = 5'h12;
	localparam raddr_t RA_T2_VAL    = 5'h13;
	localparam raddr_t RA_T3_CTL    = 5'h14;
	localparam raddr_t RA_T3_VAL    = 5'h15;
	localparam raddr_t RA_T4_CTL    = 5'h16;
	localparam raddr_t RA_T4_HI     = 5'h17;
	localparam raddr_t RA_T4_LO     = 5'h18;
	localparam raddr_t RA_T5_CTL    = 5'h19;
	localparam raddr_t RA_T5_HI     = 5'h1a;
	localparam raddr_t RA_T5_LO     = 5'h1b;
	localparam raddr_t RA_IST0      = 5'h1c;
	localparam raddr_t RA_IST1      = 5'h1d;
	localparam raddr_t RA_IMSK0     = 5'h1e;
	localparam raddr_t RA_IMSK1     = 5'h1f;

	localparam int unsigned NTMR  = 6;
	localparam int unsigned RELW  = 17;
	localparam int unsigned ELAW  = 24;
	localparam int unsigned DIVW  = 25;

	localparam logic [7:0] MSK_SER     = 8'h77;
	localparam logic [7:0] MSK_STAT    = 8'h87;
	localparam logic [7:0] MSK_AUX     = 8'h9f;
	localparam logic [7:0] MSK_CTL_LO  = 8'h59;
	localparam logic [7:0] MSK_CTL_HI  = 8'h5f;
	localparam logic [7:0] MSK_IMSK0   = 8'h47;
	localparam logic [7:0] MSK_IMSK1   = 8'h3f;
	localparam logic [7:0] MSK_LOW7    = 8'h7f;
	localparam logic [RELW-1:0] FULL8  = 17'h00100;
	localparam logic [RELW-1:0] FULL16 = 17'h10000;

	localparam int unsigned BIT_PB4    = 4;
	localparam int unsigned BIT_BORROW = 5;
	localparam int unsigned BIT_IRQ    = 6;

	function automatic raddr_t ctl_addr(input logic [2:0] t);
		case (t)
			3'd0:    ctl_addr = RA_T0_CTL;
			3'd1:    ctl_addr = RA_T1_CTL;
			3'd2:    ctl_addr = RA_T2_CTL;
			3'd3:    ctl_addr = RA_T3_CTL;
			3'd4:    ctl_addr = RA_T4_CTL;
			default: ctl_addr = RA_T5_CTL;
		endcase
	endfunction

	function automatic raddr_t val_addr(input logic [2:0] t);
		case (t)
			3'd0:    val_addr = RA_T0_VAL;
			3'd1:    val_addr = RA_T1_VAL;
			3'd2:    val_addr = RA_T2_VAL;
			3'd3:    val_addr = RA_T3_VAL;
			3'd4:    val_addr = RA_T4_HI;
			default: val_addr = RA_T5_HI;
		endcase
	endfunction

endpackage

// ===== hw/rtl/io_timer_interrupt_controller_top.sv =====
// Top level of the I/O timer and interrupt controller block.
//
// Usage: one command word enters on the slave stream (s_tvalid/s_tready/s_tdata/s_tuser)
// and exactly one result word leaves on the master stream (m_tvalid/m_tready/m_tdata).
// s_tuser carries the operation: read, write, tick, key code delivery or peek.
// Reads, peeks, writes and key deliveries pass from acceptance through the execute state to
// the result register. A tick walks the six timers one after another; each running,
// loaded timer takes a memory read state, a check state, the bit-serial remainder unit
// (one restoring step per dividend bit and a done step) and a write-back state, while an
// idle timer takes only the read and check states.
// Timer reload values and elapsed counts sit in two
// six-entry synchronous memories; entries never written read as zero through per-entry
// valid bits that reset clears. Only one word is in flight, so a memory write and a
// read of the same entry never overlap.
// Reset clears the register file, latches, the remote flag, the run bits and the valid bits
// at once; no clearing pass is needed. The result register parts the two sides: a new
// command word is accepted while an earlier result still waits, and when the receiver
// stalls the finished result holds the block before it can deliver the next one.
module io_timer_interrupt_controller_top
	import itic_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: reg_address[7:0], write_data[15:8], tick_cycles[31:16],
	// cassette_level[32], zero fill[39:33]
	input  logic [39:0] s_tdata,
	// s_tuser: operation[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: read_data[7:0], irq_line[8], motor_on[9], tape_byte_valid[10],
	// tape_byte[18:11], zero fill[23:19]
	output logic [23:0] m_tdata
);

	state_t state_q;

	// Latched command word.
	logic [2:0]  op_q;
	logic [7:0]  addr_q;
	logic [7:0]  wdat_q;
	logic [15:0] cyc_q;
	logic        lvl_q;

	// Register file and side state.
	logic [7:0] rf_q [32];
	logic [7:0] rf_d [32];
	logic [7:0] hle_q, hle_d;
	logic [7:0] hlf_q, hlf_d;
	logic       remote_q, remote_d;
	logic [NTMR-1:0] run_q, run_d;

	// Timer memories.
	logic [RELW-1:0] rel_mem [NTMR];
	logic [ELAW-1:0] ela_mem [NTMR];
	logic [NTMR-1:0] rel_vld_q;
	logic [NTMR-1:0] ela_vld_q;
	logic [RELW-1:0] rel_rd_s1;
	logic [ELAW-1:0] ela_rd_s1;
	logic            rel_v_s1;
	logic            ela_v_s1;
	logic            rel_we;
	logic [2:0]      rel_wa;
	logic [RELW-1:0] rel_wd;
	logic            ela_we;
	logic [2:0]      ela_wa;
	logic [ELAW-1:0] ela_wd;

	// Tick sequencing.
	logic [2:0]      tmr_q;
	logic [RELW-1:0] rel_q;
	logic [3:0]      shift_q;
	logic            borrow_q;
	logic [RELW-1:0] rel_cur;
	logic [ELAW-1:0] ela_cur;
	logic [3:0]      shift_cur;
	logic [1:0]      sel_cur;
	logic [DIVW-1:0] period_cur;
	logic [DIVW-1:0] total_cur;
	logic            tmr_active;
	logic            div_start;
	logic            div_done;
	logic [DIVW-1:0] div_rem;
	logic            last_tmr;

	// Result staging and output register.
	logic [7:0]  res_rd_q, rd_d;
	logic        res_tv_q, tv_d;
	logic [7:0]  res_tb_q, tb_d;
	logic        m_tvalid_q;
	logic [23:0] m_tdata_q;
	logic        pending;
	logic        out_load;

	assign s_tready = (state_q == ST_IDLE);
	assign pending  = |((rf_q[RA_IST0] | rf_q[RA_IST1]) & MSK_LOW7);
	assign out_load = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);
	assign last_tmr = (tmr_q == 3'(NTMR - 1));

	// Timer parameters seen in the check cycle.
	always_comb begin
		rel_cur    = rel_v_s1 ? rel_rd_s1 : '0;
		ela_cur    = ela_v_s1 ? ela_rd_s1 : '0;
		sel_cur    = (tmr_q < 3'd4) ? rf_q[ctl_addr(tmr_q)][4:3]
		                            : {1'b0, rf_q[ctl_addr(tmr_q)][3]};
		case (sel_cur)
			2'd0:    shift_cur = 4'd0;
			2'd1:    shift_cur = 4'd3;
			2'd2:    shift_cur = 4'd6;
			default: shift_cur = 4'd8;
		endcase
		period_cur = DIVW'(rel_cur) << shift_cur;
		total_cur  = DIVW'(ela_cur) + DIVW'(cyc_q);
		tmr_active = run_q[tmr_q] && (rel_cur != '0);
		div_start  = (state_q == ST_TCHK) && tmr_active;
	end

	itic_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (total_cur),
		.divisor   (period_cur),
		.done      (div_done),
		.remainder (div_rem)
	);

	// Register-file update for every operation and for the tick write-back.
	always_comb begin
		raddr_t          a5;
		logic            in_rng;
		logic [7:0]      v;
		logic [2:0]      t;
		logic [ELAW-1:0] ela_new;
		logic [ELAW-1:0] ela_sc;
		logic [RELW-1:0] remain;
		raddr_t          ca;
		raddr_t          va;

		a5      = addr_q[4:0];
		in_rng  = (addr_q[7:5] == 3'd0);
		v       = wdat_q;
		t       = 3'd0;
		ela_new = div_rem[ELAW-1:0];
		ela_sc  = ela_new >> shift_q;
		remain  = rel_q - ela_sc[RELW-1:0];
		ca      = ctl_addr(tmr_q);
		va      = val_addr(tmr_q);

		rf_d     = rf_q;
		hle_d    = hle_q;
		hlf_d    = hlf_q;
		remote_d = remote_q;
		run_d    = run_q;
		rel_we   = 1'b0;
		rel_wa   = tmr_q;
		rel_wd   = '0;
		ela_we   = 1'b0;
		ela_wa   = tmr_q;
		ela_wd   = '0;
		rd_d     = '0;
		tv_d     = 1'b0;
		tb_d     = '0;

		if (state_q == ST_EXEC) begin
			case (op_q)
				OP_READ: begin
					if (in_rng) begin
						rd_d = rf_q[a5];
						if (a5 == RA_IST0 || a5 == RA_IST1) begin
							rd_d[7] = pending;
						end
						case (a5)
							RA_PORT_B: begin
								rd_d[BIT_PB4] = 1'b1;
							end
							RA_TAPE_STAT: begin
								rd_d[BIT_BORROW] = 1'b1;
							end
							RA_PORT_D: begin
								if (remote_q) begin
									rf_d[RA_PORT_D][7] = lvl_q;
									rd_d[7] = lvl_q;
								end
							end
							RA_SER_STAT, RA_IST0: begin
								rf_d[a5] = '0;
							end
							RA_T0_CTL, RA_T1_CTL, RA_T2_CTL, RA_T3_CTL, RA_T4_CTL,
							RA_T5_CTL: begin
								case (a5)
									RA_T0_CTL: t = 3'd0;
									RA_T1_CTL: t = 3'd1;
									RA_T2_CTL: t = 3'd2;
									RA_T3_CTL: t = 3'd3;
									RA_T4_CTL: t = 3'd4;
									default:   t = 3'd5;
								endcase
								rf_d[a5][BIT_BORROW] = 1'b0;
								rf_d[RA_IST1][t]     = 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				OP_WRITE: begin
					if (in_rng) begin
						case (a5)
							RA_DIR_A, RA_DIR_B, RA_DIR_C, RA_DIR_D, RA_TAPE_DATA: begin
								rf_d[a5] = v;
								if (a5 == RA_TAPE_DATA && remote_q) begin
									tv_d = 1'b1;
									tb_d = v;
									rf_d[RA_TAPE_STAT][BIT_BORROW] = 1'b1;
								end
							end
							RA_PORT_A, RA_PORT_B: begin
								rf_d[a5] = v & rf_q[a5 - 5'd1];
							end
							RA_PORT_C: begin
								rf_d[a5] = (v & rf_q[RA_DIR_C]) | ~rf_q[RA_DIR_C];
							end
							RA_PORT_D: begin
								rf_d[a5] = v & rf_q[RA_DIR_D];
								remote_d = v[BIT_IRQ];
							end
							RA_SER_MODE: begin
								rf_d[a5] = v & MSK_SER;
							end
							RA_SER_CTL: begin
								rf_d[a5] = v & MSK_SER;
								if (v[4] && rf_q[RA_IMSK0][0]) begin
									rf_d[RA_IST0][0] = 1'b1;
								end
							end
							RA_SER_STAT: begin
								rf_d[a5] = v & MSK_STAT;
							end
							RA_SER_AUX: begin
								rf_d[a5] = v & MSK_AUX;
							end
							RA_TAPE_STAT: begin
								rf_d[a5] = v;
								rf_d[RA_IMSK0][BIT_IRQ] = v[BIT_IRQ];
							end
							RA_T0_CTL, RA_T1_CTL, RA_T2_CTL, RA_T3_CTL, RA_T4_CTL,
							RA_T5_CTL: begin
								case (a5)
									RA_T0_CTL: t = 3'd0;
									RA_T1_CTL: t = 3'd1;
									RA_T2_CTL: t = 3'd2;
									RA_T3_CTL: t = 3'd3;
									RA_T4_CTL: t = 3'd4;
									default:   t = 3'd5;
								endcase
								rf_d[a5] = v & ((t < 3'd2) ? MSK_CTL_LO : MSK_CTL_HI);
								rf_d[RA_IST1][t] = 1'b0;
								ela_we = 1'b1;
								ela_wa = t;
								run_d[t] = (t < 3'd2) ? v[0] : (v[2:0] != 3'd0);
								// Timer 0 started with a bare enable code flags the tape side.
								if (t == 3'd0 && v == 8'h01) begin
									rf_d[RA_TAPE_STAT][BIT_BORROW] = 1'b1;
								end
								rf_d[RA_IMSK1][t] = v[BIT_IRQ];
							end
							RA_T0_VAL, RA_T1_VAL, RA_T2_VAL, RA_T3_VAL: begin
								rf_d[a5] = v;
								rel_we = 1'b1;
								rel_wa = 3'((a5 - RA_T0_VAL) >> 1);
								rel_wd = (v == 8'd0) ? FULL8 : RELW'(v);
								ela_we = 1'b1;
								ela_wa = rel_wa;
							end
							RA_T4_HI: begin
								hle_d = v;
							end
							RA_T5_HI: begin
								hlf_d = v;
							end
							RA_T4_LO, RA_T5_LO: begin
								rel_we = 1'b1;
								if (a5 == RA_T4_LO) begin
									rf_d[RA_T4_HI] = hle_q;
									rel_wa = 3'd4;
									rel_wd = ({hle_q, v} == 16'd0) ? FULL16 : RELW'({hle_q, v});
								end else begin
									rf_d[RA_T5_HI] = hlf_q;
									rel_wa = 3'd5;
									rel_wd = ({hlf_q, v} == 16'd0) ? FULL16 : RELW'({hlf_q, v});
								end
								rf_d[a5] = v;
								ela_we = 1'b1;
								ela_wa = rel_wa;
							end
							RA_IMSK0: begin
								rf_d[a5] = v & MSK_IMSK0;
								rf_d[RA_TAPE_STAT][BIT_IRQ] = v[BIT_IRQ];
							end
							RA_IMSK1: begin
								rf_d[a5] = v & MSK_IMSK1;
								rf_d[RA_T0_CTL][BIT_IRQ] = v[0];
								rf_d[RA_T1_CTL][BIT_IRQ] = v[1];
								rf_d[RA_T2_CTL][BIT_IRQ] = v[2];
								rf_d[RA_T3_CTL][BIT_IRQ] = v[3];
								rf_d[RA_T4_CTL][BIT_IRQ] = v[4];
								rf_d[RA_T5_CTL][BIT_IRQ] = v[5];
							end
							default: begin
							end
						endcase
					end
				end
				OP_KEY: begin
					rf_d[RA_PORT_A] = v;
					if (rf_q[RA_IMSK0][0]) begin
						rf_d[RA_IST0][0] = 1'b1;
					end
				end
				OP_PEEK: begin
					if (in_rng) begin
						rd_d = rf_q[a5];
						if (a5 == RA_IST0 || a5 == RA_IST1) begin
							rd_d[7] = pending;
						end
						if (a5 == RA_PORT_B) begin
							rd_d[BIT_PB4] = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end

		if (state_q == ST_TWB) begin
			ela_we = 1'b1;
			ela_wa = tmr_q;
			ela_wd = ela_new;
			if (borrow_q) begin
				rf_d[ca][BIT_BORROW] = 1'b1;
				if (rf_q[RA_IMSK1][tmr_q]) begin
					rf_d[RA_IST1][tmr_q] = 1'b1;
				end
			end
			// The count left in the period goes back to the value register(s).
			if (tmr_q < 3'd4) begin
				rf_d[va] = remain[7:0];
			end else begin
				rf_d[va]        = remain[15:8];
				rf_d[va + 5'd1] = remain[7:0];
			end
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tmr_q      <= '0;
			hle_q      <= '0;
			hlf_q      <= '0;
			remote_q   <= 1'b0;
			run_q      <= '0;
			rel_vld_q  <= '0;
			ela_vld_q  <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < 32; i++) begin
				rf_q[i] <= '0;
			end
		end else begin
			rf_q     <= rf_d;
			hle_q    <= hle_d;
			hlf_q    <= hlf_d;
			remote_q <= remote_d;
			run_q    <= run_d;
			if (rel_we) begin
				rel_vld_q[rel_wa] <= 1'b1;
			end
			if (ela_we) begin
				ela_vld_q[ela_wa] <= 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						tmr_q   <= '0;
						state_q <= (s_tuser == OP_TICK) ? ST_TRD : ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_FIN;
				end
				ST_TRD: begin
					state_q <= ST_TCHK;
				end
				ST_TCHK: begin
					if (tmr_active) begin
						state_q <= ST_TDIV;
					end else if (last_tmr) begin
						state_q <= ST_FIN;
					end else begin
						tmr_q   <= tmr_q + 3'd1;
						state_q <= ST_TRD;
					end
				end
				ST_TDIV: begin
					if (div_done) begin
						state_q <= ST_TWB;
					end
				end
				ST_TWB: begin
					if (last_tmr) begin
						state_q <= ST_FIN;
					end else begin
						tmr_q   <= tmr_q + 3'd1;
						state_q <= ST_TRD;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command latch, check-cycle captures, result staging and output payload.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q   <= s_tuser;
			addr_q <= s_tdata[7:0];
			wdat_q <= s_tdata[15:8];
			cyc_q  <= s_tdata[31:16];
			lvl_q  <= s_tdata[32];
		end
		if (state_q == ST_TCHK) begin
			rel_q    <= rel_cur;
			shift_q  <= shift_cur;
			borrow_q <= (total_cur >= period_cur);
		end
		if (state_q == ST_EXEC) begin
			res_rd_q <= rd_d;
			res_tv_q <= tv_d;
			res_tb_q <= tb_d;
		end else if (state_q == ST_TRD) begin
			res_rd_q <= '0;
			res_tv_q <= 1'b0;
			res_tb_q <= '0;
		end
		if (out_load) begin
			m_tdata_q <= {5'd0, res_tb_q, res_tv_q, remote_q, pending, res_rd_q};
		end
	end

	// Timer memories: one write port each, registered read in the fetch cycle.
	always_ff @(posedge clk) begin
		if (rel_we) begin
			rel_mem[rel_wa] <= rel_wd;
		end
		if (ela_we) begin
			ela_mem[ela_wa] <= ela_wd;
		end
		if (state_q == ST_TRD) begin
			rel_rd_s1 <= rel_mem[tmr_q];
			ela_rd_s1 <= ela_mem[tmr_q];
			rel_v_s1  <= rel_vld_q[tmr_q];
			ela_v_s1  <= ela_vld_q[tmr_q];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== hw/rtl/itic_mod.sv =====
// Bit-serial remainder unit: one restoring step per cycle over the dividend bits.
module itic_mod
	import itic_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [DIVW-1:0] dividend,
	input  logic [DIVW-1:0] divisor,
	output logic            done,
	output logic [DIVW-1:0] remainder
);

	localparam int unsigned CNTW = $clog2(DIVW);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [DIVW-1:0] rem_q;
	logic [DIVW-1:0] dvd_q;
	logic [DIVW-1:0] dvs_q;
	logic [DIVW:0]   trial;
	logic [DIVW:0]   diff;

	// Shift the next dividend bit in; subtract when the partial value reaches the divisor.
	assign trial = {rem_q, dvd_q[DIVW-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(DIVW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= (trial >= {1'b0, dvs_q}) ? diff[DIVW-1:0] : trial[DIVW-1:0];
			dvd_q <= {dvd_q[DIVW-2:0], 1'b0};
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ===== hw/rtl/itic_checker.sv =====
// Port-level checker for the I/O timer block and its bind to the top level.
module itic_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// A result that is not taken stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// One word is worked on at a time: acceptance closes the input for the next cycle.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word accepted while busy");

	// A tape byte shows only with its valid flag.
	a_tape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[10] |-> m_tdata[18:11] == 8'd0)
		else $error("tape byte without valid flag");

	// The fill bits above the result fields stay zero.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:19] == 5'd0)
		else $error("fill bits set in result word");

endmodule

bind io_timer_interrupt_controller_top itic_checker u_itic_checker (.*);

// ===== tb/io_timer_interrupt_controller_top_tb.sv =====
// Self-checking testbench for the I/O timer and interrupt controller top level.
module io_timer_interrupt_controller_top_tb;
	import itic_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Operation codes that the block must treat as no-ops.
	localparam logic [2:0] OP_NOP_LO = 3'd5;
	localparam logic [2:0] OP_NOP_HI = 3'd7;

	localparam int N_RANDOM = 1730;
	// Idling stops for the last stretch of the run.
	localparam int QUIET_TAIL = 150;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 200;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	io_timer_interrupt_controller_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// One command word as it is presented on the slave stream.
	typedef struct {
		logic [2:0]  op;
		logic [7:0]  addr;
		logic [7:0]  data;
		logic [15:0] cycles;
		logic        level;
		bit          typed;     // read_data below is fixed by hand
		logic [7:0]  typed_rd;
	} cmd_t;

	// One result word, split into its fields.
	typedef struct {
		logic [7:0] rd;
		logic       irq;
		logic       motor;
		logic       tvalid;
		logic [7:0] tbyte;
	} result_t;

	// Shadow copy of the block state kept by the predictor.
	logic [7:0]  shadow_regs [32];
	logic [7:0]  shadow_latch_e;
	logic [7:0]  shadow_latch_f;
	logic [16:0] shadow_reload [NTMR];
	logic [31:0] shadow_elapsed [NTMR];
	bit          shadow_run [NTMR];
	bit          shadow_remote;

	// Control and value register of each timer.
	raddr_t timer_ctl [NTMR] = '{RA_T0_CTL, RA_T1_CTL, RA_T2_CTL, RA_T3_CTL, RA_T4_CTL,
		RA_T5_CTL};
	raddr_t timer_val [NTMR] = '{RA_T0_VAL, RA_T1_VAL, RA_T2_VAL, RA_T3_VAL, RA_T4_HI,
		RA_T5_HI};

	result_t pending_results [$];
	bit      failed;
	bit      quiet;
	bit      stim_done;
	int      cycle_count;

	function automatic bit irq_pending();
		return ((shadow_regs[RA_IST0] | shadow_regs[RA_IST1]) & MSK_LOW7) != 8'h00;
	endfunction

	// The top status bit of both status registers mirrors the pending state.
	function automatic void update_summary();
		if (irq_pending()) begin
			shadow_regs[RA_IST0][7] = 1'b1;
			shadow_regs[RA_IST1][7] = 1'b1;
		end else begin
			shadow_regs[RA_IST0][7] = 1'b0;
			shadow_regs[RA_IST1][7] = 1'b0;
		end
	endfunction

	// A source only latches into status when its mask bit is set.
	function automatic void post_irq(input bit grp, input logic [7:0] src);
		raddr_t mreg;
		raddr_t sreg;
		mreg = grp ? RA_IMSK1 : RA_IMSK0;
		sreg = grp ? RA_IST1 : RA_IST0;
		if ((shadow_regs[mreg] & src) != 8'h00)
			shadow_regs[sreg] |= src;
		update_summary();
	endfunction

	function automatic logic [7:0] bus_read(input logic [7:0] a, input logic lvl);
		logic [7:0] v;
		if (a >= 8'd32)
			return 8'h00;
		v = shadow_regs[a];
		case (a[4:0])
			RA_PORT_B: return v | (8'h01 << BIT_PB4);
			RA_TAPE_STAT: return v | (8'h01 << BIT_BORROW);
			RA_PORT_D: begin
				// Under remote the top bit follows the cassette input pin.
				if (shadow_remote) begin
					shadow_regs[RA_PORT_D][7] = lvl;
					v = shadow_regs[RA_PORT_D];
				end
				return v;
			end
			RA_SER_STAT: begin
				shadow_regs[a] = 8'h00;
				return v;
			end
			RA_IST0: begin
				shadow_regs[a] = 8'h00;
				update_summary();
				return v;
			end
			default: ;
		endcase
		// Reading a timer control clears its borrow flag and its status bit.
		for (int t = 0; t < NTMR; t++) begin
			if (timer_ctl[t] == a[4:0]) begin
				shadow_regs[a][BIT_BORROW] = 1'b0;
				shadow_regs[RA_IST1][t] = 1'b0;
				update_summary();
			end
		end
		return v;
	endfunction

	function automatic void load_timer(input int t, input logic [16:0] v,
		input logic [16:0] full);
		shadow_reload[t] = (v == 17'd0) ? full : v;
		shadow_elapsed[t] = 0;
	endfunction

	function automatic void ctl_write(input int t, input logic [7:0] v);
		shadow_regs[timer_ctl[t]] = v & ((t < 2) ? MSK_CTL_LO : MSK_CTL_HI);
		shadow_regs[RA_IST1][t] = 1'b0;
		shadow_elapsed[t] = 0;
		shadow_run[t] = (v & ((t < 2) ? 8'h01 : 8'h07)) != 8'h00;
		// Writing exactly 0x01 to timer 0 control flags a tape borrow.
		if (t == 0 && v == 8'h01)
			shadow_regs[RA_TAPE_STAT][BIT_BORROW] = 1'b1;
		shadow_regs[RA_IMSK1][t] = v[BIT_IRQ];
		update_summary();
	endfunction

	function automatic void bus_write(input logic [7:0] a, input logic [7:0] v,
		inout result_t r);
		raddr_t ra;
		ra = a[4:0];
		case (ra)
			RA_DIR_A, RA_DIR_B, RA_DIR_C, RA_DIR_D: shadow_regs[ra] = v;
			RA_PORT_A, RA_PORT_B: shadow_regs[ra] = v & shadow_regs[ra - 5'd1];
			RA_PORT_C: shadow_regs[ra] = (v & shadow_regs[RA_DIR_C]) | ~shadow_regs[RA_DIR_C];
			RA_PORT_D: begin
				shadow_regs[ra] = v & shadow_regs[RA_DIR_D];
				shadow_remote = v[6];
			end
			RA_SER_MODE: shadow_regs[ra] = v & MSK_SER;
			RA_SER_CTL: begin
				shadow_regs[ra] = v & MSK_SER;
				if (v[4])
					post_irq(1'b0, 8'h01);
			end
			RA_SER_STAT: shadow_regs[ra] = v & MSK_STAT;
			RA_SER_AUX: shadow_regs[ra] = v & MSK_AUX;
			RA_TAPE_STAT: begin
				shadow_regs[ra] = v;
				shadow_regs[RA_IMSK0][BIT_IRQ] = v[BIT_IRQ];
			end
			RA_TAPE_DATA: begin
				shadow_regs[ra] = v;
				if (shadow_remote) begin
					r.tvalid = 1'b1;
					r.tbyte = v;
					shadow_regs[RA_TAPE_STAT][BIT_BORROW] = 1'b1;
				end
			end
			RA_T0_CTL: ctl_write(0, v);
			RA_T1_CTL: ctl_write(1, v);
			RA_T2_CTL: ctl_write(2, v);
			RA_T3_CTL: ctl_write(3, v);
			RA_T4_CTL: ctl_write(4, v);
			RA_T5_CTL: ctl_write(5, v);
			RA_T0_VAL, RA_T1_VAL, RA_T2_VAL, RA_T3_VAL: begin
				shadow_regs[ra] = v;
				load_timer((ra - RA_T0_VAL) >> 1, {9'd0, v}, FULL8);
			end
			RA_T4_HI: shadow_latch_e = v;
			RA_T5_HI: shadow_latch_f = v;
			RA_T4_LO: begin
				shadow_regs[RA_T4_HI] = shadow_latch_e;
				shadow_regs[RA_T4_LO] = v;
				load_timer(4, {1'b0, shadow_latch_e, v}, FULL16);
			end
			RA_T5_LO: begin
				shadow_regs[RA_T5_HI] = shadow_latch_f;
				shadow_regs[RA_T5_LO] = v;
				load_timer(5, {1'b0, shadow_latch_f, v}, FULL16);
			end
			RA_IMSK0: begin
				shadow_regs[ra] = v & MSK_IMSK0;
				shadow_regs[RA_TAPE_STAT][BIT_IRQ] = v[6];
			end
			RA_IMSK1: begin
				shadow_regs[ra] = v & MSK_IMSK1;
				for (int t = 0; t < NTMR; t++)
					shadow_regs[timer_ctl[t]][BIT_IRQ] = v[t];
			end
			default: ;
		endcase
	endfunction

	// Advance one timer by the tick amount of the command; a tick flags its borrow at most once.
	function automatic void advance_timer(input int t, input logic [15:0] cyc);
		logic [1:0]  sel;
		logic [31:0] scale;
		logic [31:0] period;
		logic [31:0] total;
		logic [31:0] remaining;
		raddr_t      ca;
		raddr_t      va;
		ca = timer_ctl[t];
		va = timer_val[t];
		if (!shadow_run[t] || shadow_reload[t] == 17'd0)
			return;
		sel = (t < 4) ? shadow_regs[ca][4:3] : {1'b0, shadow_regs[ca][3]};
		case (sel)
			2'd0: scale = 1;
			2'd1: scale = 8;
			2'd2: scale = 64;
			default: scale = 256;
		endcase
		period = shadow_reload[t] * scale;
		total = shadow_elapsed[t] + cyc;
		if (total >= period) begin
			shadow_regs[ca][BIT_BORROW] = 1'b1;
			post_irq(1'b1, 8'h01 << t);
		end
		shadow_elapsed[t] = total % period;
		remaining = shadow_reload[t] - shadow_elapsed[t] / scale;
		if (t < 4) begin
			shadow_regs[va] = remaining[7:0];
		end else begin
			shadow_regs[va] = remaining[15:8];
			shadow_regs[va + 5'd1] = remaining[7:0];
		end
		if (shadow_regs[RA_IST1][t] == 1'b0)
			update_summary();
	endfunction

	// Apply one command to the shadow state and return the result it must produce.
	function automatic result_t predict_result(input cmd_t c);
		result_t r;
		r = '{rd: 8'h00, irq: 1'b0, motor: 1'b0, tvalid: 1'b0, tbyte: 8'h00};
		case (c.op)
			OP_READ: r.rd = bus_read(c.addr, c.level);
			OP_WRITE: begin
				if (c.addr < 8'd32)
					bus_write(c.addr, c.data, r);
			end
			OP_TICK: begin
				for (int t = 0; t < NTMR; t++)
					advance_timer(t, c.cycles);
			end
			OP_KEY: begin
				shadow_regs[RA_PORT_A] = c.data;
				post_irq(1'b0, 8'h01);
			end
			OP_PEEK: begin
				if (c.addr < 8'd32)
					r.rd = (c.addr[4:0] == RA_PORT_B) ?
						(shadow_regs[RA_PORT_B] | (8'h01 << BIT_PB4)) : shadow_regs[c.addr];
			end
			default: ;
		endcase
		r.irq = irq_pending();
		r.motor = shadow_remote;
		return r;
	endfunction

	function automatic cmd_t mk(input logic [2:0] op, input logic [7:0] a,
		input logic [7:0] d, input logic [15:0] cyc, input logic lvl);
		cmd_t c;
		c = '{op: op, addr: a, data: d, cycles: cyc, level: lvl, typed: 1'b0, typed_rd: 8'h00};
		return c;
	endfunction

	function automatic cmd_t mk_typed(input logic [2:0] op, input logic [7:0] a,
		input logic [7:0] rd);
		cmd_t c;
		c = mk(op, a, 8'h00, 16'h0000, 1'b0);
		c.typed = 1'b1;
		c.typed_rd = rd;
		return c;
	endfunction

	// Random commands lean toward timer setup and ticks so that timers really count.
	function automatic cmd_t random_cmd();
		cmd_t c;
		int   pick;
		int   sz;
		c = mk(OP_READ, 8'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 32) begin
			c.op = OP_WRITE;
			sz = $urandom_range(0, 9);
			if (sz < 5)
				c.addr = 8'($urandom_range(RA_T0_CTL, RA_IMSK1));
			else if (sz < 9)
				c.addr = 8'($urandom_range(0, 31));
			// Running timers with small prescalers are favored.
			if (c.addr[4:0] inside {RA_T0_CTL, RA_T1_CTL, RA_T2_CTL, RA_T3_CTL,
				RA_T4_CTL, RA_T5_CTL} && $urandom_range(0, 2) != 0)
				c.data = {c.data[7:5], 2'($urandom_range(0, 1)), c.data[2:1], 1'b1};
		end else if (pick < 55) begin
			c.op = OP_TICK;
			sz = $urandom_range(0, 9);
			if (sz < 6)
				c.cycles = 16'($urandom_range(0, 400));
			else if (sz == 9)
				c.cycles = 16'hffff;
		end else if (pick < 75) begin
			c.op = OP_READ;
			if ($urandom_range(0, 7) != 0)
				c.addr = 8'($urandom_range(0, 31));
		end else if (pick < 86) begin
			c.op = OP_PEEK;
			if ($urandom_range(0, 7) != 0)
				c.addr = 8'($urandom_range(0, 31));
		end else if (pick < 94) begin
			c.op = OP_KEY;
		end else begin
			c.op = 3'($urandom_range(OP_NOP_LO, OP_NOP_HI));
		end
		return c;
	endfunction

	// Directed opening sequence: reset values, edge addresses, special cases.
	cmd_t directed [$];

	initial begin
		directed.push_back(mk_typed(OP_READ, 8'h00, 8'h00));
		directed.push_back(mk_typed(OP_PEEK, 8'h03, 8'h10));
		directed.push_back(mk_typed(OP_READ, 8'h0c, 8'h20));
		directed.push_back(mk_typed(OP_READ, 8'hff, 8'h00));
		directed.push_back(mk_typed(OP_NOP_HI, 8'h00, 8'h00));
		directed.push_back(mk(OP_WRITE, 8'hff, 8'hff, 16'hffff, 1'b1));
		directed.push_back(mk(OP_WRITE, 8'h1e, 8'hff, 16'h0000, 1'b0));
		directed.push_back(mk(OP_KEY, 8'h00, 8'hff, 16'h0000, 1'b0));
		directed.push_back(mk(OP_READ, 8'h1c, 8'h00, 16'h0000, 1'b0));
		directed.push_back(mk(OP_WRITE, 8'h1c, 8'hff, 16'h0000, 1'b0));
		directed.push_back(mk(OP_WRITE, 8'h00, 8'hf0, 16'h0000, 1'b0));
		directed.push_back(mk(OP_WRITE, 8'h01, 8'hff, 16'h0000, 1'b0));
		directed.push_back(mk(OP_WRITE, 8'h06, 8'hff, 16'h0000, 1'b0));
		directed.push_back(mk(OP_WRITE, 8'h07, 8'h40, 16'h0000, 1'b0));
		directed.push_back(mk(OP_READ, 8'h07, 8'h00, 16'h0000, 1'b1));
		directed.push_back(mk(OP_WRITE, 8'h0d, 8'ha5, 16'h0000, 1'b0));
		directed.push_back(mk(OP_WRITE, 8'h0e, 8'h01, 16'h0000, 1'b0));
		directed.push_back(mk(OP_WRITE, 8'h0f, 8'h00, 16'h0000, 1'b0));
		directed.push_back(mk(OP_WRITE, 8'h1f, 8'h3f, 16'h0000, 1'b0));
		directed.push_back(mk(OP_WRITE, 8'h18, 8'h00, 16'h0000, 1'b0));
		directed.push_back(mk(OP_WRITE, 8'h16, 8'h4f, 16'h0000, 1'b0));
		directed.push_back(mk(OP_TICK, 8'h00, 8'h00, 16'hffff, 1'b0));
		directed.push_back(mk(OP_TICK, 8'h00, 8'h00, 16'h0000, 1'b0));
		directed.push_back(mk(OP_READ, 8'h16, 8'h00, 16'h0000, 1'b0));
		directed.push_back(mk(OP_READ, 8'h1d, 8'h00, 16'h0000, 1'b0));
	end

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Stimulus: each word is held until the block takes it, with random gaps between.
	// Valid drops only when a gap follows, so it gets one assignment per clock edge.
	task automatic send_word(input cmd_t c);
		result_t r;
		int      gap;
		if (!quiet && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= c.op;
		s_tdata <= {7'd0, c.level, c.cycles, c.data, c.addr};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = predict_result(c);
		if (c.typed)
			r.rd = c.typed_rd;
		pending_results.push_back(r);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_READ;
		m_tready = 1'b0;
		failed = 1'b0;
		quiet = 1'b0;
		stim_done = 1'b0;
		for (int i = 0; i < 32; i++)
			shadow_regs[i] = 8'h00;
		shadow_latch_e = 8'h00;
		shadow_latch_f = 8'h00;
		for (int t = 0; t < NTMR; t++) begin
			shadow_reload[t] = '0;
			shadow_elapsed[t] = 0;
			shadow_run[t] = 1'b0;
		end
		shadow_remote = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_word(directed[i]);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - QUIET_TAIL)
				quiet = 1'b1;
			send_word(random_cmd());
		end
		s_tvalid <= 1'b0;
		stim_done = 1'b1;
	end

	// Result side: compare each delivered word with the oldest prediction.
	int stall_left = 0;

	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word %h", $realtime, m_tdata);
				failed = 1'b1;
			end else begin
				exp_r = pending_results.pop_front();
				if (m_tdata[7:0] !== exp_r.rd) begin
					$display("%0t: read_data expected %h actual %h", $realtime, exp_r.rd,
						m_tdata[7:0]);
					failed = 1'b1;
				end
				if (m_tdata[8] !== exp_r.irq) begin
					$display("%0t: irq_line expected %b actual %b", $realtime, exp_r.irq,
						m_tdata[8]);
					failed = 1'b1;
				end
				if (m_tdata[9] !== exp_r.motor) begin
					$display("%0t: motor_on expected %b actual %b", $realtime, exp_r.motor,
						m_tdata[9]);
					failed = 1'b1;
				end
				if (m_tdata[10] !== exp_r.tvalid) begin
					$display("%0t: tape_byte_valid expected %b actual %b", $realtime,
						exp_r.tvalid, m_tdata[10]);
					failed = 1'b1;
				end
				if (m_tdata[18:11] !== exp_r.tbyte) begin
					$display("%0t: tape_byte expected %h actual %h", $realtime, exp_r.tbyte,
						m_tdata[18:11]);
					failed = 1'b1;
				end
			end
		end
		// Receiver stalls come in short bursts, and stop for the tail of the run.
		if (quiet) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left <= $urandom_range(0, 7);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial cycle_count = 0;

	initial begin
		@(posedge stim_done);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed && pending_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== io_timer_interrupt_controller_top.f =====
hw/rtl/itic_pkg.sv
hw/rtl/itic_mod.sv
hw/rtl/io_timer_interrupt_controller_top.sv
hw/rtl/itic_checker.sv
tb/io_timer_interrupt_controller_top_tb.sv
